// ===== rtl/drop_tail_packet_queue_unit_assert.svh =====
// Assertion macros shared by the drop-tail packet queue RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef DROP_TAIL_PACKET_QUEUE_UNIT_ASSERT_SVH
`define DROP_TAIL_PACKET_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define DTPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low
`define DTPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dtpq_pkg.sv =====
// Shared constants and types for the drop-tail packet queue.
// No dependencies; imported by every module of the block.
package dtpq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int CTR_W       = 32;
    localparam int SUM_W       = 48;
    localparam int OCC_W       = 6;

    // item mode codes
    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_SERVE   = 1'b1;

    // contents of one cell of the chain
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] stamp;
    } t_cell;

    // chain-wide control for one beat
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    // first-stage result handed to the totals stage
    typedef struct packed {
        logic              vld;
        logic              acc;
        logic              drp;
        logic              srv;
        logic [TIME_W-1:0] wait_time;
        logic [OCC_W-1:0]  occ;
    } t_s1;

endpackage

// ===== rtl/dtpq_cell.sv =====
// One slot of the timestamp chain: holds a stamp and its valid bit.
// Depends on dtpq_pkg. Cell 0 is the oldest entry; pops shift toward it.
module dtpq_cell
    import dtpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic              i_prev_valid,
    input  t_cell             i_next,
    input  logic [TIME_W-1:0] i_push_stamp,
    output t_cell             o_cell
);

    logic              r_valid;
    logic [TIME_W-1:0] r_stamp;
    logic              n_valid;
    logic [TIME_W-1:0] n_stamp;

    // pop takes the neighbour's entry; push fills the first empty cell
    always_comb begin
        n_valid = r_valid;
        n_stamp = r_stamp;
        if (i_ctl.pop) begin
            n_valid = i_next.valid;
            n_stamp = i_next.stamp;
        end else if (i_ctl.push && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_stamp = i_push_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stamp carries no reset
    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.stamp = r_stamp;

endmodule

// ===== rtl/dtpq_totals.sv =====
// Second stage: saturating totals and the registered result beat.
// Depends on dtpq_pkg; fed by the first stage of the top level.
module dtpq_totals
    import dtpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_s1               i_s1,
    output logic              o_done,
    output logic              o_accepted,
    output logic              o_dropped,
    output logic              o_served,
    output logic [TIME_W-1:0] o_wait_time,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic [CTR_W-1:0]  o_drop_total,
    output logic [CTR_W-1:0]  o_accept_total,
    output logic [SUM_W-1:0]  o_wait_sum
);

    logic              r_done;
    logic              r_acc;
    logic              r_drp;
    logic              r_srv;
    logic [TIME_W-1:0] r_wait;
    logic [OCC_W-1:0]  r_occ;
    logic [CTR_W-1:0]  r_drop_total;
    logic [CTR_W-1:0]  r_accept_total;
    logic [SUM_W-1:0]  r_wait_sum;
    logic [CTR_W-1:0]  n_drop_total;
    logic [CTR_W-1:0]  n_accept_total;
    logic [SUM_W-1:0]  n_wait_sum;
    logic [SUM_W:0]    w_sum_ext;

    assign w_sum_ext = {1'b0, r_wait_sum} + (SUM_W + 1)'(i_s1.wait_time);

    // saturating updates
    always_comb begin
        n_drop_total   = r_drop_total;
        n_accept_total = r_accept_total;
        n_wait_sum     = r_wait_sum;
        if (i_s1.vld) begin
            if (i_s1.drp && (r_drop_total != '1)) begin
                n_drop_total = r_drop_total + CTR_W'(1);
            end
            if (i_s1.acc && (r_accept_total != '1)) begin
                n_accept_total = r_accept_total + CTR_W'(1);
            end
            if (i_s1.srv) begin
                n_wait_sum = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done         <= 1'b0;
            r_drop_total   <= '0;
            r_accept_total <= '0;
            r_wait_sum     <= '0;
        end else begin
            r_done         <= i_s1.vld;
            r_drop_total   <= n_drop_total;
            r_accept_total <= n_accept_total;
            r_wait_sum     <= n_wait_sum;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_s1.vld) begin
            r_acc  <= i_s1.acc;
            r_drp  <= i_s1.drp;
            r_srv  <= i_s1.srv;
            r_wait <= i_s1.wait_time;
            r_occ  <= i_s1.occ;
        end
    end

    assign o_done         = r_done;
    assign o_accepted     = r_acc;
    assign o_dropped      = r_drp;
    assign o_served       = r_srv;
    assign o_wait_time    = r_wait;
    assign o_occupancy    = r_occ;
    assign o_drop_total   = r_drop_total;
    assign o_accept_total = r_accept_total;
    assign o_wait_sum     = r_wait_sum;

endmodule

// ===== rtl/drop_tail_packet_queue_unit.sv =====
// Top level of the drop-tail packet queue: cell chain, first stage, totals.
// Depends on dtpq_pkg, dtpq_cell, dtpq_totals and the assertion header.
//
//  channel  | direction | handshake           | beat fields
//  ---------+-----------+---------------------+----------------------------------
//  item     | in        | start & !busy       | i_mode, i_now_time
//  result   | out       | o_done (one cycle)  | o_accepted .. o_wait_sum
//
// One item per clock; busy stays low. A taken item is registered first in the
// first stage (fill count, flags, wait subtraction), then in the totals stage
// with the 48-bit saturating sum. The head of the queue is always cell 0, so
// a serve needs no indexed read. Reset is synchronous and clears the cell
// valid bits, the fill count and the totals. The receiver cannot stall.
`include "drop_tail_packet_queue_unit_assert.svh"

module drop_tail_packet_queue_unit
    import dtpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_mode,
    input  logic [TIME_W-1:0] i_now_time,
    output logic              o_done,
    output logic              o_accepted,
    output logic              o_dropped,
    output logic              o_served,
    output logic [TIME_W-1:0] o_wait_time,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic [CTR_W-1:0]  o_drop_total,
    output logic [CTR_W-1:0]  o_accept_total,
    output logic [SUM_W-1:0]  o_wait_sum
);

    logic             w_take;
    logic             w_full;
    logic             w_empty;
    t_cell_ctl        w_ctl;
    t_cell            w_cell [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [TIME_W:0]  w_diff;
    t_s1              r_s1;
    t_s1              n_s1;

    assign busy    = 1'b0;
    assign w_take  = start && !busy;
    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctl.push = w_take && (i_mode == MODE_ARRIVAL) && !w_full;
    assign w_ctl.pop  = w_take && (i_mode == MODE_SERVE) && !w_empty;

    // chain of cells, entry 0 oldest
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell w_next;
        logic  w_prev_valid;

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end

        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_cell[g-1].valid;
        end

        dtpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid (w_prev_valid),
            .i_next       (w_next),
            .i_push_stamp (i_now_time),
            .o_cell       (w_cell[g])
        );
    end

    // waiting time against the head stamp, floored at zero
    assign w_diff = {1'b0, i_now_time} - {1'b0, w_cell[0].stamp};

    // first stage: fill count, per-beat flags, wait time and occupancy
    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        n_s1.vld       = w_take;
        n_s1.acc       = w_ctl.push;
        n_s1.drp       = w_take && (i_mode == MODE_ARRIVAL) && w_full;
        n_s1.srv       = w_ctl.pop;
        n_s1.wait_time = (w_ctl.pop && !w_diff[TIME_W]) ? w_diff[TIME_W-1:0] : '0;
        n_s1.occ       = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1    <= '0;
        end else begin
            r_count <= n_count;
            r_s1    <= n_s1;
        end
    end

    dtpq_totals u_totals (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s1           (r_s1),
        .o_done         (o_done),
        .o_accepted     (o_accepted),
        .o_dropped      (o_dropped),
        .o_served       (o_served),
        .o_wait_time    (o_wait_time),
        .o_occupancy    (o_occupancy),
        .o_drop_total   (o_drop_total),
        .o_accept_total (o_accept_total),
        .o_wait_sum     (o_wait_sum)
    );

    // checks
    `DTPQ_ASSERT_IMP(a_head_matches_count, i_clk, i_rst_n, 1'b1, (w_empty == !w_cell[0].valid), "head cell valid disagrees with fill count")
    `DTPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, (r_count <= CNT_W'(QUEUE_DEPTH)), "fill count beyond queue depth")
    `DTPQ_ASSERT_NXT(a_full_drops, i_clk, i_rst_n, (w_take && (i_mode == MODE_ARRIVAL) && w_full), (r_s1.drp && (r_count == $past(r_count))), "arrival on full queue not dropped")
    `DTPQ_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, r_s1.vld, (o_done && $onehot0({o_accepted, o_dropped, o_served})), "result beat missing or flags clash")

endmodule
